// ===== sv/tofc_pkg.sv =====
// ----------------------------------------------------------------------------
// tofc_pkg
// Shared widths, constants, register codes and types for the hit
// time-of-flight correction unit.
// ----------------------------------------------------------------------------
package tofc_pkg;

    localparam int POS_W   = 20;
    localparam int TIME_W  = 24;
    localparam int OUT_W   = 23;
    localparam int ABS_W   = POS_W;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int RECIP_W = 26;
    localparam int PROD_W  = ROOT_W + RECIP_W;
    localparam int FRAC_W  = 32;
    localparam int FLT_W   = PROD_W - FRAC_W;

    // round(2^32 * 4 / 299.792458)
    localparam logic [RECIP_W-1:0] TOF_RECIP = 26'd57305875;

    // -161.875 mm in 1/16 mm
    localparam logic signed [POS_W-1:0] VZ_RESET = -20'sd2590;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 24;
    localparam int ADDR_W     = 4;

    localparam logic [1:0] REG_VERTEX_X = 2'd0;
    localparam logic [1:0] REG_VERTEX_Y = 2'd1;
    localparam logic [1:0] REG_VERTEX_Z = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] vx;
        logic signed [POS_W-1:0] vy;
        logic signed [POS_W-1:0] vz;
    } tofc_cfg_t;

endpackage

// ===== sv/hit_time_of_flight_correction_unit.sv =====
// ----------------------------------------------------------------------------
// hit_time_of_flight_correction_unit
// Subtracts the light flight time from the vertex from each hit time.
// ----------------------------------------------------------------------------
// One hit per cycle in while s_tready is high, one corrected time per hit out,
// in order. The path from the input transfer to m_tvalid runs through three
// stages for offset, squares and sum, 21 square-root stages (one root bit each),
// two stages for the reciprocal multiply and the clamp, and the output register.
// The output side has one skid entry, so s_tready drops only once a result is
// held there while m_tready is low. Vertex registers sit at byte addresses 0, 4 and 8.
module hit_time_of_flight_correction_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tofc_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input hits
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [23:0] hit_time, [43:24] pos_x, [63:44] pos_y, [83:64] pos_z, [87:84] zero
    input  logic [tofc_pkg::IN_DATA_W-1:0]    s_tdata,
    // corrected times
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [22:0] corrected_time, [23] zero
    output logic [tofc_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import tofc_pkg::*;

    tofc_cfg_t cfg_reg;
    logic      cfg_wr;

    logic                     pipe_en;
    logic                     sq_valid;
    logic signed [TIME_W-1:0] sq_time;
    logic [SUM_W-1:0]         sq_sum;
    logic                     rt_valid;
    logic signed [TIME_W-1:0] rt_time;
    logic [ROOT_W-1:0]        rt_root;
    logic                     res_valid;
    logic [OUT_W-1:0]         res_data;

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             pop;
    logic             push;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vx <= '0;
            cfg_reg.vy <= '0;
            cfg_reg.vz <= VZ_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_VERTEX_X: cfg_reg.vx <= pwdata[POS_W-1:0];
                REG_VERTEX_Y: cfg_reg.vy <= pwdata[POS_W-1:0];
                REG_VERTEX_Z: cfg_reg.vz <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_VERTEX_X: prdata = 32'(cfg_reg.vx);
            REG_VERTEX_Y: prdata = 32'(cfg_reg.vy);
            REG_VERTEX_Z: prdata = 32'(cfg_reg.vz);
            default:      prdata = '0;
        endcase
    end

    assign pipe_en  = ~skid_valid_reg;
    assign s_tready = pipe_en;

    tofc_delta_sq u_delta_sq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .cfg     (cfg_reg),
        .valid_i (s_tvalid),
        .time_i  (s_tdata[23:0]),
        .pos_x_i (s_tdata[43:24]),
        .pos_y_i (s_tdata[63:44]),
        .pos_z_i (s_tdata[83:64]),
        .valid_o (sq_valid),
        .time_o  (sq_time),
        .sum_o   (sq_sum)
    );

    tofc_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .valid_i (sq_valid),
        .time_i  (sq_time),
        .sum_i   (sq_sum),
        .valid_o (rt_valid),
        .time_o  (rt_time),
        .root_o  (rt_root)
    );

    tofc_flight u_flight (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .valid_i  (rt_valid),
        .time_i   (rt_time),
        .dist_i   (rt_root),
        .valid_o  (res_valid),
        .result_o (res_data)
    );

    // output register with one skid entry
    assign pop  = m_valid_reg & m_tready;
    assign push = pipe_en & res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg || pop) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (!m_valid_reg || pop) begin
                m_data_reg <= res_data;
            end else begin
                skid_data_reg <= res_data;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held without a valid output");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_tready |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid entry lost during stall");

    a_stall_freezes_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(res_data) && $stable(res_valid))
        else $error("pipeline tail moved while stalled");

    a_full_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_tready |=> !skid_valid_reg && m_tvalid)
        else $error("skid entry not moved to output");

endmodule

// ===== sv/tofc_delta_sq.sv =====
// ----------------------------------------------------------------------------
// tofc_delta_sq
// Three stages: vertex offset and magnitude, squares, sum of squares.
// ----------------------------------------------------------------------------
module tofc_delta_sq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  tofc_pkg::tofc_cfg_t           cfg,
    input  logic                          valid_i,
    input  logic signed [23:0]            time_i,
    input  logic signed [19:0]            pos_x_i,
    input  logic signed [19:0]            pos_y_i,
    input  logic signed [19:0]            pos_z_i,
    output logic                          valid_o,
    output logic signed [23:0]            time_o,
    output logic [41:0]                   sum_o
);
    import tofc_pkg::*;

    logic signed [POS_W:0] dx;
    logic signed [POS_W:0] dy;
    logic signed [POS_W:0] dz;

    logic [ABS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0] sum_reg;
    logic signed [TIME_W-1:0] t1_reg, t2_reg, t3_reg;
    logic v1_reg, v2_reg, v3_reg;

    assign dx = {pos_x_i[POS_W-1], pos_x_i} - {cfg.vx[POS_W-1], cfg.vx};
    assign dy = {pos_y_i[POS_W-1], pos_y_i} - {cfg.vy[POS_W-1], cfg.vy};
    assign dz = {pos_z_i[POS_W-1], pos_z_i} - {cfg.vz[POS_W-1], cfg.vz};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_i;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg  <= dx[POS_W] ? ABS_W'(-dx) : dx[ABS_W-1:0];
            ay_reg  <= dy[POS_W] ? ABS_W'(-dy) : dy[ABS_W-1:0];
            az_reg  <= dz[POS_W] ? ABS_W'(-dz) : dz[ABS_W-1:0];
            t1_reg  <= time_i;
            sqx_reg <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sqy_reg <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
            sqz_reg <= SQ_W'(az_reg) * SQ_W'(az_reg);
            t2_reg  <= t1_reg;
            sum_reg <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
            t3_reg  <= t2_reg;
        end
    end

    assign valid_o = v3_reg;
    assign time_o  = t3_reg;
    assign sum_o   = sum_reg;

endmodule

// ===== sv/tofc_isqrt.sv =====
// ----------------------------------------------------------------------------
// tofc_isqrt
// Pipelined truncating integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tofc_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          valid_i,
    input  logic signed [23:0]            time_i,
    input  logic [41:0]                   sum_i,
    output logic                          valid_o,
    output logic signed [23:0]            time_o,
    output logic [20:0]                   root_o
);
    import tofc_pkg::*;

    localparam int STAGES = ROOT_W;

    logic [SUM_W-1:0]         n_stage   [STAGES];
    logic [SUM_W-1:0]         res_stage [STAGES];
    logic signed [TIME_W-1:0] t_stage   [STAGES];
    logic                     v_stage   [STAGES];

    logic [SUM_W-1:0]         n_reg   [STAGES];
    logic [SUM_W-1:0]         res_reg [STAGES];
    logic signed [TIME_W-1:0] t_reg   [STAGES];
    logic                     v_reg   [STAGES];

    assign n_stage[0]   = sum_i;
    assign res_stage[0] = '0;
    assign t_stage[0]   = time_i;
    assign v_stage[0]   = valid_i;

    genvar g;
    generate
        for (g = 1; g < STAGES; g++) begin : g_link
            assign n_stage[g]   = n_reg[g-1];
            assign res_stage[g] = res_reg[g-1];
            assign t_stage[g]   = t_reg[g-1];
            assign v_stage[g]   = v_reg[g-1];
        end

        for (g = 0; g < STAGES; g++) begin : g_step
            localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * g);
            logic [SUM_W-1:0] trial;

            assign trial = res_stage[g] + BIT;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[g] <= 1'b0;
                end else if (en) begin
                    v_reg[g] <= v_stage[g];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    t_reg[g] <= t_stage[g];
                    if (n_stage[g] >= trial) begin
                        n_reg[g]   <= n_stage[g] - trial;
                        res_reg[g] <= (res_stage[g] >> 1) + BIT;
                    end else begin
                        n_reg[g]   <= n_stage[g];
                        res_reg[g] <= res_stage[g] >> 1;
                    end
                end
            end
        end
    endgenerate

    assign valid_o = v_reg[STAGES-1];
    assign time_o  = t_reg[STAGES-1];
    assign root_o  = res_reg[STAGES-1][ROOT_W-1:0];

endmodule

// ===== sv/tofc_flight.sv =====
// ----------------------------------------------------------------------------
// tofc_flight
// Distance to flight time by fixed reciprocal, subtract and clamp at zero.
// ----------------------------------------------------------------------------
module tofc_flight (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          valid_i,
    input  logic signed [23:0]            time_i,
    input  logic [20:0]                   dist_i,
    output logic                          valid_o,
    output logic [22:0]                   result_o
);
    import tofc_pkg::*;

    logic [PROD_W-1:0]        prod_reg;
    logic signed [TIME_W-1:0] t_reg;
    logic [OUT_W-1:0]         result_reg;
    logic                     v1_reg, v2_reg;
    logic signed [TIME_W:0]   diff;

    assign diff = {t_reg[TIME_W-1], t_reg} - (TIME_W+1)'(prod_reg[PROD_W-1:FRAC_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_i;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= PROD_W'(dist_i) * PROD_W'(TOF_RECIP);
            t_reg      <= time_i;
            result_reg <= diff[TIME_W] ? '0 : diff[OUT_W-1:0];
        end
    end

    assign valid_o  = v2_reg;
    assign result_o = result_reg;

endmodule

// ===== bench/hit_time_of_flight_correction_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_time_of_flight_correction_unit_tb
// Streams hits through the correction unit and checks each corrected time
// against a local computation of vertex distance, flight time and clamp.
// Directed extremes and register writes come first, then an output hold-off,
// then random hits over several vertex settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module hit_time_of_flight_correction_unit_tb;

    import tofc_pkg::*;

    localparam int PIPE_LATENCY = 27;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic signed [POS_W-1:0]  POS_MAX  = 20'sh7FFFF;
    localparam logic signed [POS_W-1:0]  POS_MIN  = -20'sh80000;
    localparam logic signed [TIME_W-1:0] TIME_MAX = 24'sh7FFFFF;
    localparam logic signed [TIME_W-1:0] TIME_MIN = -24'sh800000;

    typedef struct packed {
        logic signed [TIME_W-1:0] hit_time;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
    } hit_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    tofc_cfg_t             vertex;
    logic [OUT_W-1:0]      expected_times[$];
    logic [OUT_W-1:0]      next_time;
    int                    fail_count;
    int                    cycle_count;
    int                    src_idle_pct;
    int                    snk_stall_pct;
    int                    hold_count;

    hit_time_of_flight_correction_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ---------------- prediction ----------------
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        for (int b = 21; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= n) begin
                root = probe;
            end
        end
        return root;
    endfunction

    function automatic logic [OUT_W-1:0] tof_corrected(input hit_t h);
        longint          dx;
        longint          dy;
        longint          dz;
        longint unsigned root_dist;
        longint unsigned flight;
        longint          diff;
        dx        = longint'(h.pos_x) - longint'(vertex.vx);
        dy        = longint'(h.pos_y) - longint'(vertex.vy);
        dz        = longint'(h.pos_z) - longint'(vertex.vz);
        root_dist = floor_sqrt(longint'(dx * dx + dy * dy + dz * dz));
        flight    = (root_dist * longint'(TOF_RECIP)) >> FRAC_W;
        diff      = longint'(h.hit_time) - longint'(flight);
        if (diff < 0) begin
            diff = 0;
        end
        return diff[OUT_W-1:0];
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic hit_t make_hit(input logic signed [TIME_W-1:0] t,
                                      input logic signed [POS_W-1:0] x,
                                      input logic signed [POS_W-1:0] y,
                                      input logic signed [POS_W-1:0] z);
        hit_t h;
        h.hit_time = t;
        h.pos_x    = x;
        h.pos_y    = y;
        h.pos_z    = z;
        return h;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_coord(input logic signed [POS_W-1:0] c);
        case ($urandom_range(3))
            0: begin
                return $urandom_range(1) ? POS_MAX : POS_MIN;
            end
            1: begin
                return c + POS_W'($urandom_range(2000)) - POS_W'(1000);
            end
            default: begin
                return POS_W'($urandom());
            end
        endcase
    endfunction

    // flight times top out near 24000, so bias times into that band
    function automatic logic signed [TIME_W-1:0] rand_time();
        case ($urandom_range(3))
            0: begin
                return TIME_W'($urandom_range(40000) - 2000);
            end
            1: begin
                case ($urandom_range(2))
                    0: return TIME_MAX;
                    1: return TIME_MIN;
                    default: return '0;
                endcase
            end
            default: begin
                return TIME_W'($urandom());
            end
        endcase
    endfunction

    function automatic hit_t random_hit();
        return make_hit(rand_time(), rand_coord(vertex.vx), rand_coord(vertex.vy),
                        rand_coord(vertex.vz));
    endfunction

    task automatic send_hit(input hit_t h);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0, h.pos_z, h.pos_y, h.pos_x, h.hit_time};
        do @(posedge aclk); while (!s_tready);
        expected_times.push_back(tof_corrected(h));
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_times.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic signed [POS_W-1:0] val);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {12'($urandom()), val};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_VERTEX_X: vertex.vx = val;
            REG_VERTEX_Y: vertex.vy = val;
            REG_VERTEX_Z: vertex.vz = val;
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_vertex(input logic signed [POS_W-1:0] vx,
                              input logic signed [POS_W-1:0] vy,
                              input logic signed [POS_W-1:0] vz);
        wait_drain();
        apb_write(REG_VERTEX_X, vx);
        apb_write(REG_VERTEX_Y, vy);
        apb_write(REG_VERTEX_Z, vz);
    endtask

    // ---------------- tests ----------------
    task automatic test_reset_vertex();
        send_hit(make_hit(24'sd0, 20'sd0, 20'sd0, 20'sd0));
        send_hit(make_hit(24'sd34, 20'sd0, 20'sd0, 20'sd0));
        send_hit(make_hit(24'sd35, 20'sd0, 20'sd0, 20'sd0));
        send_hit(make_hit(-24'sd1, 20'sd0, 20'sd0, 20'sd0));
        send_hit(make_hit(TIME_MAX, 20'sd0, 20'sd0, 20'sd0));
        send_hit(make_hit(TIME_MIN, 20'sd0, 20'sd0, 20'sd0));
        send_hit(make_hit(24'sd1, 20'sd0, 20'sd0, VZ_RESET));
    endtask

    task automatic test_field_extremes();
        set_vertex(POS_MAX, POS_MAX, POS_MAX);
        send_hit(make_hit(TIME_MAX, POS_MIN, POS_MIN, POS_MIN));
        send_hit(make_hit(24'sd24000, POS_MIN, POS_MIN, POS_MIN));
        send_hit(make_hit(24'sd0, POS_MAX, POS_MAX, POS_MAX));
        set_vertex(POS_MIN, POS_MIN, POS_MIN);
        send_hit(make_hit(TIME_MAX, POS_MAX, POS_MAX, POS_MAX));
        send_hit(make_hit(24'sd25000, POS_MAX, POS_MAX, POS_MAX));
        send_hit(make_hit(TIME_MIN, POS_MAX, POS_MIN, POS_MAX));
        send_hit(make_hit(24'sd12000, POS_MAX, POS_MIN, POS_MIN));
    endtask

    task automatic test_register_writes();
        set_vertex(20'sd1000, -20'sd2000, 20'sd3000);
        wait_drain();
        apb_write(REG_UNUSED, POS_W'($urandom()));
        send_hit(make_hit(24'sd500, 20'sd0, 20'sd0, 20'sd0));
        wait_drain();
        apb_write(REG_VERTEX_X, POS_W'($urandom()));
        send_hit(make_hit(TIME_MAX, 20'sd0, 20'sd0, 20'sd0));
        wait_drain();
        apb_write(REG_VERTEX_Y, POS_W'($urandom()));
        send_hit(make_hit(TIME_MAX, 20'sd0, 20'sd0, 20'sd0));
        wait_drain();
        apb_write(REG_VERTEX_Z, POS_W'($urandom()));
        send_hit(make_hit(TIME_MAX, 20'sd0, 20'sd0, 20'sd0));
    endtask

    task automatic test_output_backpressure();
        wait_drain();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        @(posedge aclk);
        hold_count = 300;
        repeat (120) send_hit(random_hit());
    endtask

    task automatic test_random_hits(input int n, input int src_pct, input int snk_pct,
                                    input logic signed [POS_W-1:0] vx,
                                    input logic signed [POS_W-1:0] vy,
                                    input logic signed [POS_W-1:0] vz);
        set_vertex(vx, vy, vz);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        repeat (n) send_hit(random_hit());
    endtask

    // ---------------- result side ----------------
    always @(negedge aclk) begin
        if (hold_count > 0) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_times.size() == 0) begin
                $error("unexpected corrected_time transfer: actual %0d", m_tdata[OUT_W-1:0]);
                fail_count++;
            end else begin
                next_time = expected_times.pop_front();
                if (m_tdata[OUT_W-1:0] !== next_time) begin
                    $error("corrected_time mismatch: expected %0d, actual %0d",
                           next_time, m_tdata[OUT_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[OUT_DATA_W-1:OUT_W] !== '0) begin
                    $error("pad mismatch: expected 0, actual %0d",
                           m_tdata[OUT_DATA_W-1:OUT_W]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_count    = 0;
        vertex.vx     = '0;
        vertex.vy     = '0;
        vertex.vz     = VZ_RESET;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_vertex();
        test_field_extremes();
        test_register_writes();
        test_output_backpressure();
        test_random_hits(400, 0, 0, 20'sd0, 20'sd0, VZ_RESET);
        test_random_hits(400, 85, 0, POS_MAX, POS_MIN, 20'sd0);
        test_random_hits(400, 0, 85, POS_W'($urandom()), POS_W'($urandom()),
                         POS_W'($urandom()));
        test_random_hits(400, 16, 16, POS_MIN, POS_MAX, POS_MIN);

        wait_drain();
        repeat (8) @(posedge aclk);
        if (expected_times.size() != 0) begin
            $error("corrected_time missing: %0d transfers never arrived",
                   expected_times.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== hit_time_of_flight_correction_unit.f =====
sv/tofc_pkg.sv
sv/tofc_delta_sq.sv
sv/tofc_isqrt.sv
sv/tofc_flight.sv
sv/hit_time_of_flight_correction_unit.sv
bench/hit_time_of_flight_correction_unit_tb.sv
